[rtl/pars_pkg.sv]
// Shared types and constants for the periodic acknowledge/retry sender.
`default_nettype none
package pars_pkg;

    localparam int unsigned RX_SLOTS_DEF = 8;

    localparam int unsigned SEQ_W   = 8;
    localparam int unsigned SLOT_W  = 3;
    localparam int unsigned TIMER_W = 16;
    localparam int unsigned RETRY_W = 4;
    localparam int unsigned CFG_W   = 16;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [SEQ_W-1:0] SEQ_LAST = 8'd254;

    localparam logic [TIMER_W-1:0] MSG_INTERVAL_RST = 16'd1000;
    localparam logic [TIMER_W-1:0] ACK_TIMEOUT_RST  = 16'd100;
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST  = 4'd3;
    localparam logic               ACK_REQUIRED_RST = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MSG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_TIMEOUT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_REQUIRED = 2'd3;

    typedef enum logic [1:0] {
        PH_BUILD = 2'd0,
        PH_SEND  = 2'd1,
        PH_WAIT  = 2'd2
    } t_phase;

    typedef struct packed {
        logic [TIMER_W-1:0] msg_interval;
        logic [TIMER_W-1:0] ack_timeout;
        logic [RETRY_W-1:0] max_retries;
        logic               ack_required;
    } t_cfg;

    typedef struct packed {
        logic             mode;
        logic             tick;
        logic             tx_full;
        logic             rx_valid;
        logic             rx_is_ack;
        logic [SEQ_W-1:0] rx_seq;
    } t_item;

    typedef struct packed {
        logic               send_now;
        logic [SEQ_W-1:0]   send_seq;
        logic               send_aperiodic;
        logic               rx_consume;
        logic [SLOT_W-1:0]  next_slot;
        logic [1:0]         phase;
        logic [RETRY_W-1:0] retry_count;
    } t_result;

endpackage
`default_nettype wire

[rtl/pars_in_if.sv]
// Input channel: one polling step or interrupt event per word.
`default_nettype none
interface pars_in_if;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic                      tick;
    logic                      tx_full;
    logic                      rx_valid;
    logic                      rx_is_ack;
    logic [pars_pkg::SEQ_W-1:0] rx_seq;

    modport source (output valid, mode, tick, tx_full, rx_valid, rx_is_ack, rx_seq,
                    input ready);
    modport sink   (input valid, mode, tick, tx_full, rx_valid, rx_is_ack, rx_seq,
                    output ready);
endinterface
`default_nettype wire

[rtl/pars_out_if.sv]
// Output channel: one status word per accepted input word.
`default_nettype none
interface pars_out_if;
    logic                         valid;
    logic                         ready;
    logic                         send_now;
    logic [pars_pkg::SEQ_W-1:0]   send_seq;
    logic                         send_aperiodic;
    logic                         rx_consume;
    logic [pars_pkg::SLOT_W-1:0]  next_slot;
    logic [1:0]                   phase;
    logic [pars_pkg::RETRY_W-1:0] retry_count;

    modport source (output valid, send_now, send_seq, send_aperiodic, rx_consume,
                    next_slot, phase, retry_count, input ready);
    modport sink   (input valid, send_now, send_seq, send_aperiodic, rx_consume,
                    next_slot, phase, retry_count, output ready);
endinterface
`default_nettype wire

[rtl/pars_ctrl.sv]
// Sender state: timers, phase machine, sequence, retries and receive scan.
`default_nettype none
module pars_ctrl #(
    parameter int unsigned RX_SLOTS = pars_pkg::RX_SLOTS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire pars_pkg::t_item   i_item,
    input  wire pars_pkg::t_cfg    i_cfg,
    output pars_pkg::t_result      o_result
);
    localparam int unsigned SCAN_W = (RX_SLOTS > 1) ? $clog2(RX_SLOTS) : 1;
    localparam logic [SCAN_W-1:0] SCAN_LAST = SCAN_W'(RX_SLOTS - 1);

    pars_pkg::t_phase                r_phase, n_phase;
    logic                            r_aper_flag, n_aper_flag;
    logic                            r_msg_aper, n_msg_aper;
    logic [pars_pkg::TIMER_W-1:0]    r_period_tmr, n_period_tmr;
    logic [pars_pkg::TIMER_W-1:0]    r_ack_tmr, n_ack_tmr;
    logic [pars_pkg::RETRY_W-1:0]    r_retries, n_retries;
    logic [pars_pkg::SEQ_W-1:0]      r_seq, n_seq;
    logic [SCAN_W-1:0]               r_scan, n_scan;

    logic [pars_pkg::TIMER_W-1:0]    period_dec;
    logic [pars_pkg::TIMER_W-1:0]    ack_dec;
    logic                            send_now;
    logic                            consume;
    logic                            ack_match;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= pars_pkg::PH_BUILD;
            r_aper_flag  <= 1'b0;
            r_msg_aper   <= 1'b0;
            r_period_tmr <= pars_pkg::MSG_INTERVAL_RST;
            r_ack_tmr    <= '0;
            r_retries    <= '0;
            r_seq        <= '0;
            r_scan       <= '0;
        end else if (i_en) begin
            r_phase      <= n_phase;
            r_aper_flag  <= n_aper_flag;
            r_msg_aper   <= n_msg_aper;
            r_period_tmr <= n_period_tmr;
            r_ack_tmr    <= n_ack_tmr;
            r_retries    <= n_retries;
            r_seq        <= n_seq;
            r_scan       <= n_scan;
        end
    end

    // timers count down before the phase step looks at them
    assign period_dec = (i_item.tick && r_period_tmr != '0) ? r_period_tmr - 1'b1
                                                             : r_period_tmr;
    assign ack_dec    = (i_item.tick && r_ack_tmr != '0) ? r_ack_tmr - 1'b1 : r_ack_tmr;
    assign ack_match  = i_item.rx_valid && i_item.rx_is_ack && (i_item.rx_seq == r_seq);

    always_comb begin
        n_phase      = r_phase;
        n_aper_flag  = r_aper_flag;
        n_msg_aper   = r_msg_aper;
        n_period_tmr = r_period_tmr;
        n_ack_tmr    = r_ack_tmr;
        n_retries    = r_retries;
        n_seq        = r_seq;
        n_scan       = r_scan;
        send_now     = 1'b0;
        consume      = 1'b0;
        if (i_item.mode) begin
            // interrupt: force an aperiodic build on the next polling word
            n_aper_flag  = 1'b1;
            n_phase      = pars_pkg::PH_BUILD;
            n_period_tmr = '0;
        end else begin
            n_period_tmr = period_dec;
            n_ack_tmr    = ack_dec;
            case (r_phase)
                pars_pkg::PH_SEND: begin
                    send_now = !i_item.tx_full;
                    if (i_cfg.ack_required) begin
                        n_ack_tmr = i_cfg.ack_timeout;
                        n_phase   = pars_pkg::PH_WAIT;
                    end else begin
                        n_phase   = pars_pkg::PH_BUILD;
                    end
                end
                pars_pkg::PH_WAIT: begin
                    if (ack_dec == '0) begin
                        if (r_retries < i_cfg.max_retries) begin
                            n_phase   = pars_pkg::PH_SEND;
                            n_retries = r_retries + 1'b1;
                        end else begin
                            n_phase   = pars_pkg::PH_BUILD;
                        end
                    end else if (ack_match) begin
                        n_phase = pars_pkg::PH_BUILD;
                        consume = 1'b1;
                    end else begin
                        n_scan = (r_scan == SCAN_LAST) ? '0 : r_scan + 1'b1;
                    end
                end
                default: begin
                    n_phase = pars_pkg::PH_BUILD;
                    if (period_dec == '0) begin
                        n_phase      = pars_pkg::PH_SEND;
                        n_period_tmr = i_cfg.msg_interval;
                        n_retries    = '0;
                        n_seq        = (r_seq == pars_pkg::SEQ_LAST) ? '0 : r_seq + 1'b1;
                        n_msg_aper   = r_aper_flag;
                        n_aper_flag  = 1'b0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        o_result.send_now       = send_now;
        o_result.send_seq       = n_seq;
        o_result.send_aperiodic = n_msg_aper;
        o_result.rx_consume     = consume;
        o_result.next_slot      = pars_pkg::SLOT_W'(n_scan);
        o_result.phase          = n_phase;
        o_result.retry_count    = n_retries;
    end
endmodule
`default_nettype wire

[rtl/periodic_ack_retry_sender_core.sv]
// Output: each result word is registered and appears in the cycle after its input word is accepted.
// Throughput: one input word per cycle; a new word is taken in the same cycle the
// pending result leaves, and a result held back by the receiver blocks the input.
// Reset (synchronous, active low): build phase, period timer at 1000 ticks,
// registers at their defaults, output register empty.
`default_nettype none
module periodic_ack_retry_sender_core #(
    parameter int unsigned RX_SLOTS = pars_pkg::RX_SLOTS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [pars_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [pars_pkg::CFG_W-1:0]      i_cfg_wdata,
    pars_in_if.sink                              i_in,
    pars_out_if.source                           o_out
);
    pars_pkg::t_cfg    r_cfg;
    pars_pkg::t_item   item;
    pars_pkg::t_result result;
    pars_pkg::t_result r_out;
    logic              r_out_valid;
    logic              in_ready;
    logic              accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.msg_interval <= pars_pkg::MSG_INTERVAL_RST;
            r_cfg.ack_timeout  <= pars_pkg::ACK_TIMEOUT_RST;
            r_cfg.max_retries  <= pars_pkg::MAX_RETRIES_RST;
            r_cfg.ack_required <= pars_pkg::ACK_REQUIRED_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                pars_pkg::CFG_MSG_INTERVAL: r_cfg.msg_interval <= i_cfg_wdata;
                pars_pkg::CFG_ACK_TIMEOUT:  r_cfg.ack_timeout  <= i_cfg_wdata;
                pars_pkg::CFG_MAX_RETRIES:
                    r_cfg.max_retries <= i_cfg_wdata[pars_pkg::RETRY_W-1:0];
                pars_pkg::CFG_ACK_REQUIRED: r_cfg.ack_required <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign in_ready   = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    always_comb begin
        item.mode      = i_in.mode;
        item.tick      = i_in.tick;
        item.tx_full   = i_in.tx_full;
        item.rx_valid  = i_in.rx_valid;
        item.rx_is_ack = i_in.rx_is_ack;
        item.rx_seq    = i_in.rx_seq;
    end

    pars_ctrl #(
        .RX_SLOTS (RX_SLOTS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (accept),
        .i_item   (item),
        .i_cfg    (r_cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.send_now       = r_out.send_now;
    assign o_out.send_seq       = r_out.send_seq;
    assign o_out.send_aperiodic = r_out.send_aperiodic;
    assign o_out.rx_consume     = r_out.rx_consume;
    assign o_out.next_slot      = r_out.next_slot;
    assign o_out.phase          = r_out.phase;
    assign o_out.retry_count    = r_out.retry_count;

    // a consumed ack always closes the message
    a_consume_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.rx_consume) |-> (o_out.phase == pars_pkg::PH_BUILD))
        else $error("ack consumed outside build phase");

    // after a send the phase has moved on to wait or build
    a_send_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.send_now) |-> (o_out.phase != pars_pkg::PH_SEND))
        else $error("send word left phase at send");

    // a pending word that is not taken holds off the input side
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready)
        else $error("input accepted over a stalled result");

    // an accepted word always yields a result word next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> o_out.valid)
        else $error("accepted word produced no result");
endmodule
`default_nettype wire
